// ----- src/md5_stream_hash_unit_assert.svh -----
// Assertion macros shared by the md5 stream hash checker.
// Each expects clk and arst_n to be visible where it is used.
`ifndef MD5_STREAM_HASH_UNIT_ASSERT_SVH
`define MD5_STREAM_HASH_UNIT_ASSERT_SVH

// same-cycle implication
`define MD5SH_ASSERT_SAME(label, ante, cons, text) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(text);

// next-cycle implication
`define MD5SH_ASSERT_NEXT(label, ante, cons, text) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(text);

`endif

// ----- src/md5sh_pkg.sv -----
`default_nettype none
package md5sh_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_final;
	} msg_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} dig_word_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [5:0] LEN_POS    = 6'd56;

	function automatic logic [31:0] round_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478;
			6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;
			6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;
			6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			6'd63: k = 32'heb86d391;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [1:0] phase, input logic [1:0] j);
		logic [4:0] s;
		case ({phase, j})
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// message word index used by round i
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] x;
		logic [3:0] g;
		x = i[3:0];
		case (i[5:4])
			2'd0: g = x;
			2'd1: g = x * 4'd5 + 4'd1;
			2'd2: g = x * 4'd3 + 4'd5;
			2'd3: g = x * 4'd7;
			default: g = x;
		endcase
		return g;
	endfunction

	function automatic logic [31:0] round_fn(input logic [1:0] phase,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (phase)
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (b & d) | (c & ~d);
			2'd2: f = b ^ c ^ d;
			2'd3: f = c ^ (b | ~d);
			default: f = '0;
		endcase
		return f;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] t;
		t = {x, x} << s;
		return t[63:32];
	endfunction

endpackage
`default_nettype wire

// ----- src/md5_stream_hash_unit.sv -----
// Each byte is taken while no block is being compressed.
// A full 64-byte block is compressed by load, rounds and fold on one shared round datapath.
// The final byte adds one or two such passes, then four digest words, one per cycle while dig_ready is high.
// Throughput: 1 byte per cycle within a block; bytes stall while a block is compressed.
// Reset (arst_n low, async): chaining words to the initial vector, count to zero, idle.
// The block buffer is not cleared; every byte is written before it is read.
`default_nettype none
module md5_stream_hash_unit
	import md5sh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      msg_valid,
	output logic           msg_ready,
	input  wire msg_word_t msg,
	output logic           dig_valid,
	input  wire logic      dig_ready,
	output dig_word_t      dig
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	state_t      state_q;
	logic [60:0] count_q;
	logic [31:0] chain_q [4];
	logic [6:0]  keep_q;   // bytes below this come from the buffer
	logic        mark_q;   // 0x80 at byte keep_q
	logic        len_q;    // bit length in words 14 and 15
	logic        fin_q;
	logic [5:0]  rnd_q;
	logic [1:0]  oidx_q;

	logic [31:0] blk_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, pre_q;

	logic [5:0]  pos;
	logic [5:0]  pos_next;
	logic        take;
	logic [63:0] len_bits;
	logic [3:0]  rd_g;
	logic [31:0] raw_word;
	logic [31:0] w_sel;
	logic [5:0]  rnd_next;
	logic [31:0] f_val;
	logic [31:0] t_val;
	logic [31:0] pre_next;

	assign pos      = count_q[5:0];
	assign pos_next = pos + 6'd1;
	assign take     = msg_valid && msg_ready;
	assign len_bits = {count_q, 3'b000};
	assign rnd_next = rnd_q + 6'd1;

	// padded view of one buffer word
	always_comb begin
		logic [5:0] k;
		rd_g     = (state_q == ST_LOAD) ? 4'd0 : msg_index(rnd_next);
		raw_word = blk_q[rd_g];
		w_sel    = '0;
		for (int b = 0; b < 4; b++) begin
			k = {rd_g, 2'(b)};
			if ({1'b0, k} < keep_q)
				w_sel[8*b +: 8] = raw_word[8*b +: 8];
			else if (mark_q && ({1'b0, k} == keep_q))
				w_sel[8*b +: 8] = PAD_MARK;
		end
		if (len_q && rd_g == 4'd14)
			w_sel = len_bits[31:0];
		else if (len_q && rd_g == 4'd15)
			w_sel = len_bits[63:32];
	end

	// pre_q holds a + K + w for the current round, built ahead of it in pre_next
	assign f_val    = round_fn(rnd_q[5:4], b_q, c_q, d_q);
	assign t_val    = b_q + rotl32(pre_q + f_val, rot_amount(rnd_q[5:4], rnd_q[1:0]));
	assign pre_next = ((state_q == ST_LOAD) ? chain_q[0] : d_q)
		+ round_const((state_q == ST_LOAD) ? 6'd0 : rnd_next) + w_sel;

	assign msg_ready        = (state_q == ST_IDLE);
	assign dig_valid        = (state_q == ST_OUT);
	assign dig.digest_word  = chain_q[oidx_q];
	assign dig.word_index   = oidx_q;
	assign dig.last_word    = (oidx_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			chain_q[0] <= IV_A;
			chain_q[1] <= IV_B;
			chain_q[2] <= IV_C;
			chain_q[3] <= IV_D;
			keep_q     <= '0;
			mark_q     <= 1'b0;
			len_q      <= 1'b0;
			fin_q      <= 1'b0;
			rnd_q      <= '0;
			oidx_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						count_q <= count_q + 61'd1;
						if (pos == LAST_ROUND) begin
							keep_q  <= 7'd64;
							mark_q  <= 1'b0;
							len_q   <= 1'b0;
							fin_q   <= msg.is_final;
							state_q <= ST_LOAD;
						end else if (msg.is_final) begin
							keep_q  <= {1'b0, pos_next};
							mark_q  <= 1'b1;
							len_q   <= (pos_next < LEN_POS);
							fin_q   <= 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_next;
					if (rnd_q == LAST_ROUND)
						state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					if (len_q) begin
						oidx_q  <= '0;
						state_q <= ST_OUT;
					end else if (mark_q) begin
						// marker block had no room for the length
						keep_q  <= '0;
						mark_q  <= 1'b0;
						len_q   <= 1'b1;
						state_q <= ST_LOAD;
					end else if (fin_q) begin
						// last byte closed a full block: padding starts a new one
						keep_q  <= '0;
						mark_q  <= 1'b1;
						len_q   <= 1'b1;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig_ready) begin
						oidx_q <= oidx_q + 2'd1;
						if (oidx_q == 2'd3) begin
							chain_q[0] <= IV_A;
							chain_q[1] <= IV_B;
							chain_q[2] <= IV_C;
							chain_q[3] <= IV_D;
							count_q    <= '0;
							fin_q      <= 1'b0;
							len_q      <= 1'b0;
							mark_q     <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			blk_q[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= msg.data_byte;
		if (state_q == ST_LOAD) begin
			a_q   <= chain_q[0];
			b_q   <= chain_q[1];
			c_q   <= chain_q[2];
			d_q   <= chain_q[3];
			pre_q <= pre_next;
		end else if (state_q == ST_ROUND) begin
			a_q   <= d_q;
			d_q   <= c_q;
			c_q   <= b_q;
			b_q   <= t_val;
			pre_q <= pre_next;
		end
	end

endmodule
`default_nettype wire

// ----- src/md5sh_checker.sv -----
`default_nettype none
`include "md5_stream_hash_unit_assert.svh"
module md5sh_checker
	import md5sh_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      msg_valid,
	input wire logic      msg_ready,
	input wire msg_word_t msg,
	input wire logic      dig_valid,
	input wire logic      dig_ready,
	input wire dig_word_t dig
);

	`MD5SH_ASSERT_NEXT(a_dig_hold, dig_valid && !dig_ready, dig_valid && $stable(dig), "digest word changed while stalled")
	`MD5SH_ASSERT_SAME(a_no_overlap, dig_valid, !msg_ready, "byte taken while digest pending")
	`MD5SH_ASSERT_NEXT(a_index_step, dig_valid && dig_ready && !dig.last_word, dig_valid && (dig.word_index == $past(dig.word_index) + 2'd1), "digest words out of order")
	`MD5SH_ASSERT_NEXT(a_end_digest, dig_valid && dig_ready && dig.last_word, !dig_valid, "digest ran past last word")
	`MD5SH_ASSERT_NEXT(a_quiet_byte, msg_valid && msg_ready && !msg.is_final, !dig_valid, "digest without final byte")

endmodule

bind md5_stream_hash_unit md5sh_checker u_md5sh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg_valid),
	.msg_ready (msg_ready),
	.msg       (msg),
	.dig_valid (dig_valid),
	.dig_ready (dig_ready),
	.dig       (dig)
);
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import md5sh_pkg::*;

	localparam int RANDOM_WORDS = 420;
	localparam int DRAIN_CYCLES = 160;

	localparam logic [31:0] START_VEC [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [31:0] MIX_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int ROT_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	// directed rows; digest is {D, C, B, A} where known is set
	typedef struct packed {
		logic [7:0]       data;
		logic             fin;
		logic             known;
		logic [3:0][31:0] digest;
	} vec_row_t;

	localparam int VEC_ROWS = 11;
	localparam vec_row_t VEC_TABLE [VEC_ROWS] = '{
		// "a"
		'{8'h61, 1'b1, 1'b1, {32'h61267769, 32'he299c331, 32'ha8b6f1c0, 32'hb975c10c}},
		// "abc"
		'{8'h61, 1'b0, 1'b0, '0},
		'{8'h62, 1'b0, 1'b0, '0},
		'{8'h63, 1'b1, 1'b1, {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190}},
		'{8'h00, 1'b1, 1'b0, '0},
		'{8'hff, 1'b1, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'haa, 1'b1, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b0, '0}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      msg_valid = 1'b0;
	logic      msg_ready;
	msg_word_t msg = '0;
	logic      dig_valid;
	logic      dig_ready = 1'b0;
	dig_word_t dig;

	logic [31:0] hash_state [4];
	logic [7:0]  blk_buf [64];
	logic [60:0] msg_len;
	dig_word_t   digest_q [$];

	int err_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	md5_stream_hash_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_ready(msg_ready),
		.msg(msg),
		.dig_valid(dig_valid),
		.dig_ready(dig_ready),
		.dig(dig)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		err_count++;
	endtask

	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int g, s, ph;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_buf[4*i+3], blk_buf[4*i+2], blk_buf[4*i+1], blk_buf[4*i]};
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		for (int i = 0; i < 64; i++) begin
			ph = i / 16;
			case (ph)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			s = ROT_S[ph * 4 + i % 4];
			t = a + f + w[g] + MIX_K[i];
			t = b + ((t << s) | (t >> (32 - s)));
			a = d;
			d = c;
			c = b;
			b = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
	endtask

	task automatic clear_hash();
		for (int i = 0; i < 4; i++)
			hash_state[i] = START_VEC[i];
		msg_len = '0;
	endtask

	// absorbs one accepted word; on the final byte pads and queues the digest
	task automatic absorb_byte(input logic [7:0] data, input logic fin);
		int pos;
		logic [63:0] bit_len;
		dig_word_t dw;
		pos = msg_len[5:0];
		blk_buf[pos] = data;
		msg_len = msg_len + 1'b1;
		if (pos == 63)
			compress_block();
		if (fin) begin
			bit_len = {msg_len, 3'b000};
			pos = msg_len[5:0];
			blk_buf[pos] = 8'h80;
			pos++;
			if (pos > 56) begin
				while (pos < 64)
					blk_buf[pos++] = 8'h00;
				compress_block();
				pos = 0;
			end
			while (pos < 56)
				blk_buf[pos++] = 8'h00;
			for (int i = 0; i < 8; i++)
				blk_buf[56 + i] = bit_len[8*i +: 8];
			compress_block();
			for (int i = 0; i < 4; i++) begin
				dw.digest_word = hash_state[i];
				dw.word_index = i[1:0];
				dw.last_word = (i == 3);
				digest_q.push_back(dw);
			end
			clear_hash();
		end
	endtask

	task automatic send_word(input logic [7:0] data, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= {data, fin};
		@(posedge clk);
		while (!msg_ready)
			@(posedge clk);
		absorb_byte(data, fin);
	endtask

	task automatic wait_drained();
		while (digest_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_length();
		int r;
		int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 128};
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom_range(1, 16);
		else if (r < 8)
			return edges[$urandom_range(0, 9)];
		else
			return $urandom_range(17, 150);
	endfunction

	// digest side: check, then pick the next ready
	always @(posedge clk) begin
		dig_word_t want;
		if (arst_n && dig_valid && dig_ready) begin
			if (digest_q.size() == 0) begin
				report_mismatch($sformatf("unexpected digest word %h idx %0d",
					dig.digest_word, dig.word_index));
			end else begin
				want = digest_q.pop_front();
				if (dig.digest_word !== want.digest_word)
					report_mismatch($sformatf("digest_word got %h want %h (idx %0d)",
						dig.digest_word, want.digest_word, want.word_index));
				if (dig.word_index !== want.word_index)
					report_mismatch($sformatf("word_index got %0d want %0d",
						dig.word_index, want.word_index));
				if (dig.last_word !== want.last_word)
					report_mismatch($sformatf("last_word got %0b want %0b (idx %0d)",
						dig.last_word, want.last_word, want.word_index));
			end
		end
		dig_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int sent;
		int len;
		int fill;
		logic [7:0] data;
		clear_hash();
		for (int i = 0; i < 64; i++)
			blk_buf[i] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < VEC_ROWS; r++) begin
			send_word(VEC_TABLE[r].data, VEC_TABLE[r].fin);
			if (VEC_TABLE[r].known)
				for (int i = 0; i < 4; i++)
					digest_q[digest_q.size() - 4 + i].digest_word = VEC_TABLE[r].digest[i];
		end

		// hold off until every digest is out
		msg_valid <= 1'b0;
		wait_drained();
		@(posedge clk);

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			len = pick_length();
			// last message is cut short so the total stays on target
			if (len > RANDOM_WORDS - sent)
				len = RANDOM_WORDS - sent;
			fill = $urandom_range(0, 7);
			for (int j = 0; j < len; j++) begin
				if (sent < RANDOM_WORDS / 4) begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end else if (sent < RANDOM_WORDS / 2) begin
					send_idle_pct = 84;
					recv_stall_pct = 0;
				end else if (sent < 3 * RANDOM_WORDS / 4) begin
					send_idle_pct = 0;
					recv_stall_pct = 84;
				end else begin
					send_idle_pct = 35;
					recv_stall_pct = 35;
				end
				case (fill)
					0: data = 8'h00;
					1: data = 8'hff;
					default: data = $urandom_range(0, 255);
				endcase
				send_word(data, j == len - 1);
				sent++;
			end
		end
		msg_valid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+src
src/md5sh_pkg.sv
src/md5_stream_hash_unit.sv
src/md5sh_checker.sv
bench/testbench.sv
